// ----- rtl/lmsdb_pkg.sv -----
// Package for the double-buffered LED matrix scanner.
// Holds the item types, request codes and default matrix size.
// No dependencies.
package lmsdb_pkg;

  localparam int DEF_ROWS = 8;
  localparam int DEF_COLS = 8;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_FLIP  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] row_index;
    logic [7:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic       row_serial;
    logic       row_clock;
    logic       col_serial;
    logic       col_clock;
    logic       col_latch;
    logic [2:0] scan_row;
  } out_item_t;

endpackage

// ----- rtl/led_matrix_scan_double_buffer.sv -----
// Double-buffered LED matrix row scanner: one item per clock; an accepted item passes
// the input register, then the result register. Every request (row write, flip request
// or tick) yields one result item; a tick steps one pin phase of 4*COLS+6 phases per
// row, ROWS rows per frame, and a pending flip swaps the front and back stores at the
// first tick of a frame. The rate is one item per clock while the result side takes items;
// a result-side stall reaches in_stall in the same cycle once both registers are full.
// Depends on lmsdb_pkg, lmsdb_in_reg, lmsdb_scan_core and lmsdb_out_reg.
module led_matrix_scan_double_buffer import lmsdb_pkg::*; #(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      adv;
  logic      s1_valid;
  in_item_t  s1_item;
  out_item_t res;

  lmsdb_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  lmsdb_scan_core #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv && s1_valid),
    .item   (s1_item),
    .result (res)
  );

  lmsdb_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/lmsdb_in_reg.sv -----
// Input register stage of the LED matrix scanner.
// Depends on lmsdb_pkg for the input item type.
module lmsdb_in_reg import lmsdb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     adv,
  output logic     s1_valid,
  output in_item_t s1_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  assign load      = !valid_r || adv;
  assign in_stall  = !load;
  assign valid_nxt = load ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ----- rtl/lmsdb_scan_core.sv -----
// Scan state and pin sequencing for the LED matrix scanner.
// Holds both frame stores, flip flag and row/phase counters.
// Depends on lmsdb_pkg for item types and request codes.
module lmsdb_scan_core import lmsdb_pkg::*; #(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  localparam int COL_PHASES = 2 * COLS + 2;
  localparam int ROW_PHASES = 2 + 2 * COL_PHASES;
  localparam int PW = $clog2(ROW_PHASES);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);

  logic [COLS-1:0] store_a_r [ROWS];
  logic [COLS-1:0] store_b_r [ROWS];
  logic            front_b_r, front_b_nxt;
  logic            pend_r, pend_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [PW-1:0]   phase_r, phase_nxt;

  logic            is_tick;
  logic            do_flip;
  logic            wr_en;
  logic [RW-1:0]   wr_row;
  logic [COLS-1:0] wr_bits;
  logic [COLS-1:0] val;
  logic [PW-1:0]   q;
  logic            blank;
  logic [CW-1:0]   col_idx;
  logic            rs, rc, cs, cc, cl;

  assign is_tick = (item.req_type == REQ_TICK);
  assign do_flip = is_tick && (row_r == '0) && (phase_r == '0) && pend_r;
  assign front_b_nxt = front_b_r ^ do_flip;
  assign wr_en   = (item.req_type == REQ_WRITE) && (item.row_index < 8'(ROWS));
  assign wr_row  = RW'(item.row_index);
  assign wr_bits = COLS'(item.row_bits);

  always_comb begin
    val     = front_b_nxt ? store_b_r[row_r] : store_a_r[row_r];
    q       = phase_r - PW'(2);
    blank   = 1'b0;
    rs      = 1'b0;
    rc      = 1'b0;
    cs      = 1'b0;
    cc      = 1'b0;
    cl      = 1'b0;
    col_idx = '0;
    if (q >= PW'(COL_PHASES)) begin
      q     = q - PW'(COL_PHASES);
      blank = 1'b1;
    end
    if (phase_r < PW'(2)) begin
      rc = (phase_r == '0);
      rs = (row_r == '0);
    end else if (q < PW'(2 * COLS)) begin
      col_idx = CW'(COLS - 1) - CW'(q >> 1);
      cs      = val[col_idx] && !blank;
      cc      = !q[0];
    end else begin
      cl = (q == PW'(2 * COLS));
    end
    if (!is_tick) begin
      rs = 1'b0;
      rc = 1'b0;
      cs = 1'b0;
      cc = 1'b0;
      cl = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    pend_nxt  = pend_r;
    if (item.req_type == REQ_FLIP) begin
      pend_nxt = 1'b1;
    end
    if (is_tick) begin
      if (do_flip) begin
        pend_nxt = 1'b0;
      end
      if (phase_r == PW'(ROW_PHASES - 1)) begin
        phase_nxt = '0;
        row_nxt   = (row_r == RW'(ROWS - 1)) ? '0 : row_r + RW'(1);
      end else begin
        phase_nxt = phase_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_b_r <= 1'b0;
      pend_r    <= 1'b0;
      row_r     <= '0;
      phase_r   <= '0;
    end else if (fire) begin
      front_b_r <= front_b_nxt;
      pend_r    <= pend_nxt;
      row_r     <= row_nxt;
      phase_r   <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        store_a_r[i] <= '0;
        store_b_r[i] <= '0;
      end
    end else if (fire && wr_en) begin
      if (front_b_r) begin
        store_a_r[wr_row] <= wr_bits;
      end else begin
        store_b_r[wr_row] <= wr_bits;
      end
    end
  end

  assign result.row_serial = rs;
  assign result.row_clock  = rc;
  assign result.col_serial = cs;
  assign result.col_clock  = cc;
  assign result.col_latch  = cl;
  assign result.scan_row   = 3'(row_r);

endmodule

// ----- rtl/lmsdb_out_reg.sv -----
// Result register stage of the LED matrix scanner.
// Depends on lmsdb_pkg for the result item type.
module lmsdb_out_reg import lmsdb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s1_valid,
  input  out_item_t res,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign adv       = !valid_r || !out_stall;
  assign valid_nxt = adv ? s1_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      item_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ----- sim/lmsdb_scan_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the double-buffered LED matrix scanner: models the frame stores and
// scan counters, predicts the pin levels for every accepted request item and compares
// them with the result items. Depends on lmsdb_pkg.
module lmsdb_scan_checker import lmsdb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  input  logic      end_check,
  output int        fail_count,
  output int        pins_waiting,
  output int        results_compared,
  output int        ticks_seen,
  output int        swaps_seen
);

  localparam int SCAN_ROWS   = DEF_ROWS;
  localparam int LINE_COLS   = DEF_COLS;
  localparam int LINE_PHASES = 2 * LINE_COLS + 2;
  localparam int ROW_PHASES  = 2 + 2 * LINE_PHASES;

  logic [LINE_COLS-1:0] store_a [SCAN_ROWS];
  logic [LINE_COLS-1:0] store_b [SCAN_ROWS];
  logic                 front_b;
  logic                 flip_pend;
  int unsigned          row_ctr;
  int unsigned          phase_ctr;
  out_item_t            pins_expected [$];
  bit                   closed;

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 30) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic out_item_t predict_pins(input in_item_t it);
    out_item_t            res;
    int unsigned          p;
    int unsigned          r;
    int unsigned          q;
    int unsigned          k;
    logic [LINE_COLS-1:0] val;
    res = '0;
    res.scan_row = row_ctr[2:0];
    case (it.req_type)
      REQ_WRITE: begin
        if (it.row_index < SCAN_ROWS) begin
          if (front_b) store_a[it.row_index[2:0]] = it.row_bits[LINE_COLS-1:0];
          else store_b[it.row_index[2:0]] = it.row_bits[LINE_COLS-1:0];
        end
      end
      REQ_FLIP: flip_pend = 1'b1;
      REQ_TICK: begin
        p = (phase_ctr >= ROW_PHASES) ? 0 : phase_ctr;
        r = (row_ctr >= SCAN_ROWS) ? 0 : row_ctr;
        if (r == 0 && p == 0 && flip_pend) begin
          front_b = !front_b;
          flip_pend = 1'b0;
          swaps_seen++;
        end
        res.scan_row = r[2:0];
        if (p < 2) begin
          res.row_clock = (p == 0);
          res.row_serial = (r == 0);
        end else begin
          q = p - 2;
          val = front_b ? store_b[r] : store_a[r];
          if (q >= LINE_PHASES) begin
            q -= LINE_PHASES;
            val = '0;
          end
          if (q < 2 * LINE_COLS) begin
            k = q >> 1;
            res.col_serial = val[LINE_COLS-1-k];
            res.col_clock = !q[0];
          end else begin
            res.col_latch = (q == 2 * LINE_COLS);
          end
        end
        p++;
        if (p >= ROW_PHASES) begin
          p = 0;
          r++;
          if (r >= SCAN_ROWS) r = 0;
        end
        phase_ctr = p;
        row_ctr = r;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < SCAN_ROWS; i++) begin
        store_a[i] = '0;
        store_b[i] = '0;
      end
      front_b = 1'b0;
      flip_pend = 1'b0;
      row_ctr = 0;
      phase_ctr = 0;
      pins_expected.delete();
    end else begin
      if (in_valid && !in_stall) begin
        pins_expected.push_back(predict_pins(in_item));
        if (in_item.req_type == REQ_TICK) ticks_seen++;
      end
      if (out_valid && !out_stall) begin
        if (pins_expected.size() == 0) begin
          report("result item with no request waiting");
        end else begin
          want = pins_expected.pop_front();
          check_field("row_serial", out_item.row_serial, want.row_serial);
          check_field("row_clock", out_item.row_clock, want.row_clock);
          check_field("col_serial", out_item.col_serial, want.col_serial);
          check_field("col_clock", out_item.col_clock, want.col_clock);
          check_field("col_latch", out_item.col_latch, want.col_latch);
          check_field("scan_row", out_item.scan_row, want.scan_row);
          results_compared++;
        end
      end
      if (end_check && !closed) begin
        closed = 1'b1;
        if (pins_expected.size() != 0)
          report($sformatf("%0d result items never arrived", pins_expected.size()));
      end
    end
    pins_waiting = pins_expected.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Top of the LED matrix scanner testbench: clock, reset, request stimulus and
// result-side stalls; verdict from lmsdb_scan_checker. Depends on lmsdb_pkg and the RTL.
module tb import lmsdb_pkg::*; ;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      end_check;
  int        fail_count;
  int        pins_waiting;
  int        results_compared;
  int        ticks_seen;
  int        swaps_seen;
  int        items_driven;

  led_matrix_scan_double_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  lmsdb_scan_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item),
    .end_check        (end_check),
    .fail_count       (fail_count),
    .pins_waiting     (pins_waiting),
    .results_compared (results_compared),
    .ticks_seen       (ticks_seen),
    .swaps_seen       (swaps_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  function automatic in_item_t mk(input logic [1:0] rq, input logic [7:0] idx,
                                  input logic [7:0] bits);
    in_item_t it;
    it.req_type = rq;
    it.row_index = idx;
    it.row_bits = bits;
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_driven++;
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6))
        @(posedge clk);
      out_stall <= 1'b1;
      repeat (pick_gap() + 1) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin
    in_item_t    it;
    int unsigned useful;
    int unsigned roll;
    int unsigned gap;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    end_check <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // back store first, then a double flip that lands on the first tick
    send_item(mk(REQ_WRITE, 8'd0, 8'hFF), pick_gap());
    send_item(mk(REQ_WRITE, 8'd7, 8'h01), pick_gap());
    send_item(mk(REQ_WRITE, 8'd3, 8'h80), pick_gap());
    send_item(mk(REQ_WRITE, 8'd5, 8'hA5), pick_gap());
    send_item(mk(REQ_WRITE, 8'd8, 8'h5A), pick_gap());
    send_item(mk(REQ_WRITE, 8'd255, 8'hFF), pick_gap());
    send_item(mk(REQ_UNKNOWN, 8'hFF, 8'hFF), pick_gap());
    send_item(mk(REQ_FLIP, 8'h00, 8'h00), pick_gap());
    send_item(mk(REQ_FLIP, 8'hFF, 8'hFF), pick_gap());
    repeat (15) send_item(mk(REQ_TICK, 8'($urandom), 8'($urandom)), pick_gap());
    send_item(mk(REQ_WRITE, 8'd0, 8'h00), pick_gap());

    useful = 0;
    while (useful < 750) begin
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        it = mk(REQ_TICK, 8'($urandom), 8'($urandom));
        useful++;
      end else if (roll < 93) begin
        it = mk(REQ_WRITE, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 255))
                                                       : 8'($urandom_range(0, 7)),
                8'($urandom));
        if (it.row_index < DEF_ROWS) useful++;
      end else if (roll < 98) begin
        it = mk(REQ_FLIP, 8'($urandom), 8'($urandom));
        useful++;
      end else begin
        it = mk(REQ_UNKNOWN, 8'($urandom), 8'($urandom));
      end
      gap = ((useful % 150) < 40) ? 0 : pick_gap();
      send_item(it, gap);
    end
    in_valid <= 1'b0;

    for (int n = 0; n < 5000 && pins_waiting != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Drove %0d request items (%0d phase ticks), compared %0d results,",
             items_driven, ticks_seen, results_compared);
    $display("with %0d front/back buffer swaps at frame boundaries.", swaps_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
